// ----- rtl/core/slst_pkg.sv -----
package slst_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        MODE_GET    = 3'd0,
        MODE_LOCATE = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [IDX_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } cell_op_t;

endpackage

// ----- rtl/core/slst_cell.sv -----
module slst_cell (
    input  logic                              aclk,
    input  logic [slst_pkg::IDX_W-1:0]        idx,
    input  slst_pkg::cell_op_t                op,
    input  logic signed [slst_pkg::DATA_W-1:0] left_data,
    input  logic signed [slst_pkg::DATA_W-1:0] right_data,
    output logic signed [slst_pkg::DATA_W-1:0] data,
    output logic                              match
);

    logic signed [slst_pkg::DATA_W-1:0] data_reg;
    logic signed [slst_pkg::DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (op.ins) begin
            if (idx > op.pos) begin
                data_next = left_data;
            end else if (idx == op.pos) begin
                data_next = op.val;
            end
        end else if (op.del && (idx >= op.pos)) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == op.val);

endmodule

// ----- rtl/core/sequential_list_engine_top.sv -----
// Result: a result is presented on m_tdata in the cycle after its input transfer.
// Throughput: one operation per cycle while m_tready stays high; the cell row
//   shifts all entries in the same cycle, so no operation waits on another.
// Reset (aresetn low, synchronous): list length 0, output empty, list_limit 16.
//   Entry storage is not cleared; only positions below the length are ever read.
module sequential_list_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] mode, [7:3] position, [39:8] value
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] status, [32:1] read_value,
                                   // [36:33] found_position, [41:37] length,
                                   // [42] is_empty, [47:43] zero
    // list_limit register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int DEPTH  = slst_pkg::DEPTH;
    localparam int IW     = slst_pkg::IDX_W;
    localparam int CW     = slst_pkg::CNT_W;
    localparam int DW     = slst_pkg::DATA_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CW-1:0] count_reg,      count_next;
    logic [4:0]    list_limit_reg;
    logic          m_tvalid_reg,   m_tvalid_next;
    logic [47:0]   m_tdata_reg,    m_tdata_next;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    slst_pkg::mode_t        in_mode;
    logic [4:0]             in_pos;
    logic signed [DW-1:0]   in_val;
    logic                   s_fire;

    assign in_mode = slst_pkg::mode_t'(s_tdata[2:0]);
    assign in_pos  = s_tdata[7:3];
    assign in_val  = s_tdata[39:8];

    // Output register frees up when empty or when its result is taken.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Cell row: cell i holds list position i.
    // ------------------------------------------------------------------
    slst_pkg::cell_op_t    cell_op;
    logic signed [DW-1:0]  cell_data  [DEPTH];
    logic [DEPTH-1:0]      cell_match;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DW-1:0] left_d;
        logic signed [DW-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = cell_data[g];
        end else begin : g_left
            assign left_d = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_d = cell_data[g];
        end else begin : g_right
            assign right_d = cell_data[g+1];
        end

        slst_cell u_cell (
            .aclk       (aclk),
            .idx        (IW'(g)),
            .op         (cell_op),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    // ------------------------------------------------------------------
    // Operation decode
    // ------------------------------------------------------------------
    logic [CW-1:0]        cap_now;
    logic                 pos_in_list;   // position < length
    logic                 ins_ok;
    logic                 del_ok;
    logic                 loc_hit;
    logic [IW-1:0]        loc_pos;
    logic signed [DW-1:0] entry_at_pos;
    logic                 status;
    logic signed [DW-1:0] rd_value;
    logic [IW-1:0]        fpos;

    // Effective capacity: list_limit capped at the store depth.
    assign cap_now = (list_limit_reg > 5'(DEPTH)) ? CW'(DEPTH) : CW'(list_limit_reg);

    assign pos_in_list  = (CW'(in_pos) < count_reg);
    assign ins_ok       = (count_reg < cap_now) && (CW'(in_pos) <= count_reg);
    assign del_ok       = pos_in_list;
    assign entry_at_pos = cell_data[in_pos[IW-1:0]];

    // Locate: highest matching position below the length wins.
    always_comb begin
        loc_hit = 1'b0;
        loc_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_match[i] && (CW'(i) < count_reg)) begin
                loc_hit = 1'b1;
                loc_pos = IW'(i);
            end
        end
    end

    always_comb begin
        status      = 1'b1;
        rd_value    = '0;
        fpos        = '0;
        count_next  = count_reg;
        cell_op.ins = 1'b0;
        cell_op.del = 1'b0;
        cell_op.pos = in_pos[IW-1:0];
        cell_op.val = in_val;
        case (in_mode)
            slst_pkg::MODE_GET: begin
                if (pos_in_list) begin
                    status   = 1'b0;
                    rd_value = entry_at_pos;
                end
            end
            slst_pkg::MODE_LOCATE: begin
                if (loc_hit) begin
                    status = 1'b0;
                    fpos   = loc_pos;
                end
            end
            slst_pkg::MODE_INSERT: begin
                if (ins_ok) begin
                    status      = 1'b0;
                    cell_op.ins = s_fire;
                    count_next  = count_reg + CW'(1);
                end
            end
            slst_pkg::MODE_DELETE: begin
                if (del_ok) begin
                    status      = 1'b0;
                    rd_value    = entry_at_pos;
                    cell_op.del = s_fire;
                    count_next  = count_reg - CW'(1);
                end
            end
            slst_pkg::MODE_CLEAR: begin
                status     = 1'b0;
                count_next = '0;
            end
            default: begin
                status = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b0, (count_next == '0), count_next, fpos, rd_value, status};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            list_limit_reg <= slst_pkg::LIMIT_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready) begin
                list_limit_reg <= cfg_data;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("list length beyond store depth");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_tdata[2:0] == slst_pkg::MODE_CLEAR)) |=> (count_reg == '0))
        else $error("clear left entries behind");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && cell_op.ins) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[42] == (m_tdata_reg[41:37] == 5'd0)))
        else $error("empty flag disagrees with length");
`endif

endmodule
